>>> design/wfcf_pkg.sv
// Package for the frame capture filter: payload structs, config struct,
// register indexes, frame kind codes and arithmetic constants.
// No dependencies.
`default_nettype none

package wfcf_pkg;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned CntW   = 10;
  localparam int unsigned SnapW  = 16;
  localparam int unsigned LenW   = 12;
  localparam int unsigned SecW   = 13;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned FifoDepth = 4;

  // Register indexes on the config port
  localparam logic [CfgIdxW-1:0] CfgTargetBssid   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEapolLimit    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBeaconLimit   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgProbeRespLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSnapLength    = 3'd4;

  // Frame kind codes
  localparam logic [1:0] KindEapol     = 2'd0;
  localparam logic [1:0] KindBeacon    = 2'd1;
  localparam logic [1:0] KindProbeResp = 2'd2;

  // Frame-control and ethertype bytes
  localparam logic [7:0] FcBeacon    = 8'h80;
  localparam logic [7:0] FcProbeResp = 8'h50;
  localparam logic [7:0] EthHi       = 8'h88;
  localparam logic [7:0] EthLo       = 8'h8e;
  localparam logic [LenW-1:0] FcsLen = 12'd4;

  // now / 1e6 == (now * SecRecip) >> SecShift for every 32-bit now
  localparam int unsigned RecipW   = 31;
  localparam int unsigned ProdW    = TimeW + RecipW;
  localparam int unsigned SecShift = 50;
  localparam logic [RecipW-1:0] SecRecip = 31'd1125899907;

  typedef struct packed {
    logic             mode;
    logic [7:0]       frame_control;
    logic [AddrW-1:0] addr_one;
    logic [AddrW-1:0] addr_two;
    logic [AddrW-1:0] addr_three;
    logic [31:0]      ethertype_window;
    logic [LenW-1:0]  signal_length;
    logic             is_management;
    logic [TimeW-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic             captured;
    logic [1:0]       frame_kind;
    logic [SecW-1:0]  capture_seconds;
    logic [TimeW-1:0] elapsed_us;
    logic [LenW-1:0]  original_length;
    logic [LenW-1:0]  included_length;
  } out_item_t;

  typedef struct packed {
    logic [AddrW-1:0] target_bssid;
    logic [CntW-1:0]  eapol_limit;
    logic [CntW-1:0]  beacon_limit;
    logic [CntW-1:0]  probe_resp_limit;
    logic [SnapW-1:0] snap_length;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic             clear;
    logic             hit;
    logic [1:0]       kind;
    logic [SecW-1:0]  seconds;
    logic [TimeW-1:0] now;
    logic [LenW-1:0]  olen;
    logic [LenW-1:0]  ilen;
  } fwd_t;

endpackage

`default_nettype wire

>>> design/wfcf_front.sv
// Front of the capture filter: classifies one frame header, matches the BSSID,
// computes lengths and seconds. Depends on wfcf_pkg.
`default_nettype none

module wfcf_front (
  input  wire  wfcf_pkg::in_item_t item_i,
  input  wire  wfcf_pkg::cfg_t     cfg_i,
  output wfcf_pkg::fwd_t           fwd_o
);

  logic [7:0] b0, b1, b2, b3;
  logic       has_eth;
  logic       kind_ok;
  logic [1:0] kind;
  logic       bssid_hit;
  logic [wfcf_pkg::LenW-1:0] olen;
  logic [wfcf_pkg::LenW-1:0] ilen;
  logic [wfcf_pkg::ProdW-1:0] prod;

  // Look for the ethertype at any of three offsets
  assign b0 = item_i.ethertype_window[31:24];
  assign b1 = item_i.ethertype_window[23:16];
  assign b2 = item_i.ethertype_window[15:8];
  assign b3 = item_i.ethertype_window[7:0];
  assign has_eth = (b0 == wfcf_pkg::EthHi && b1 == wfcf_pkg::EthLo) ||
                   (b1 == wfcf_pkg::EthHi && b2 == wfcf_pkg::EthLo) ||
                   (b2 == wfcf_pkg::EthHi && b3 == wfcf_pkg::EthLo);

  // Classify; EAPOL wins over the frame-control byte
  always_comb begin
    kind_ok = 1'b1;
    kind    = wfcf_pkg::KindEapol;
    priority if (has_eth) begin
      kind = wfcf_pkg::KindEapol;
    end else if (item_i.frame_control == wfcf_pkg::FcBeacon) begin
      kind = wfcf_pkg::KindBeacon;
    end else if (item_i.frame_control == wfcf_pkg::FcProbeResp) begin
      kind = wfcf_pkg::KindProbeResp;
    end else begin
      kind_ok = 1'b0;
    end
  end

  assign bssid_hit = (item_i.addr_one   == cfg_i.target_bssid) ||
                     (item_i.addr_two   == cfg_i.target_bssid) ||
                     (item_i.addr_three == cfg_i.target_bssid);

  // Drop the FCS on management frames, floor at zero, then snap-clamp
  always_comb begin
    olen = item_i.signal_length;
    if (item_i.is_management) begin
      olen = (item_i.signal_length >= wfcf_pkg::FcsLen) ?
             item_i.signal_length - wfcf_pkg::FcsLen : '0;
    end
    ilen = olen;
    if (wfcf_pkg::SnapW'(olen) > cfg_i.snap_length) begin
      ilen = cfg_i.snap_length[wfcf_pkg::LenW-1:0];
    end
  end

  // Seconds by reciprocal multiply; the queue registers the product slice
  assign prod = wfcf_pkg::ProdW'(item_i.now_us) * wfcf_pkg::ProdW'(wfcf_pkg::SecRecip);

  always_comb begin
    fwd_o.clear   = item_i.mode;
    fwd_o.hit     = !item_i.mode && kind_ok && bssid_hit;
    fwd_o.kind    = kind;
    fwd_o.seconds = prod[wfcf_pkg::SecShift +: wfcf_pkg::SecW];
    fwd_o.now     = item_i.now_us;
    fwd_o.olen    = olen;
    fwd_o.ilen    = ilen;
  end

endmodule

`default_nettype wire

>>> design/wfcf_fifo.sv
// Short queue of classified items between front and back of the filter.
// Depends on wfcf_pkg.
`default_nettype none

module wfcf_fifo #(
  parameter int unsigned Depth = wfcf_pkg::FifoDepth
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire  wfcf_pkg::fwd_t wr_data_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 rd_valid_o,
  output wfcf_pkg::fwd_t       rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  wfcf_pkg::fwd_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = entries_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && rd_valid_o;

  // Advance pointers with wrap and track the fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

>>> design/wfcf_back.sv
// Back of the capture filter: applies per-kind limits, updates counters and
// start time, and holds the result in an output register. Depends on wfcf_pkg.
`default_nettype none

module wfcf_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire  wfcf_pkg::cfg_t    cfg_i,
  input  wire                     fwd_valid_i,
  input  wire  wfcf_pkg::fwd_t    fwd_i,
  output logic                    fwd_pop_o,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output wfcf_pkg::out_item_t     out_data_o
);

  logic [wfcf_pkg::CntW-1:0]  eapol_cnt_q, eapol_cnt_d;
  logic [wfcf_pkg::CntW-1:0]  beacon_cnt_q, beacon_cnt_d;
  logic [wfcf_pkg::CntW-1:0]  probe_cnt_q, probe_cnt_d;
  logic [wfcf_pkg::TimeW-1:0] start_q, start_d;
  logic                       out_valid_q, out_valid_d;
  wfcf_pkg::out_item_t        out_q, res;
  logic first, under, take;

  // Take the next item whenever the output register is free or draining
  assign fwd_pop_o = fwd_valid_i && (!out_valid_q || !out_stall_i);

  assign first = (eapol_cnt_q == '0) && (beacon_cnt_q == '0) && (probe_cnt_q == '0);

  always_comb begin
    unique case (fwd_i.kind)
      wfcf_pkg::KindEapol:     under = eapol_cnt_q < cfg_i.eapol_limit;
      wfcf_pkg::KindBeacon:    under = beacon_cnt_q < cfg_i.beacon_limit;
      wfcf_pkg::KindProbeResp: under = probe_cnt_q < cfg_i.probe_resp_limit;
      default:                 under = 1'b0;
    endcase
  end

  assign take = fwd_i.hit && under;

  // Update counters and start time on each popped item
  always_comb begin
    eapol_cnt_d  = eapol_cnt_q;
    beacon_cnt_d = beacon_cnt_q;
    probe_cnt_d  = probe_cnt_q;
    start_d      = start_q;
    if (fwd_pop_o) begin
      if (fwd_i.clear) begin
        eapol_cnt_d  = '0;
        beacon_cnt_d = '0;
        probe_cnt_d  = '0;
        start_d      = '0;
      end else if (take) begin
        unique case (fwd_i.kind)
          wfcf_pkg::KindEapol:     eapol_cnt_d  = eapol_cnt_q + 1'b1;
          wfcf_pkg::KindBeacon:    beacon_cnt_d = beacon_cnt_q + 1'b1;
          wfcf_pkg::KindProbeResp: probe_cnt_d  = probe_cnt_q + 1'b1;
          default: ;
        endcase
        if (first) begin
          start_d = fwd_i.now;
        end
      end
    end
  end

  // Build the result; anything not captured reports all zero
  always_comb begin
    res = '0;
    if (take && !fwd_i.clear) begin
      res.captured        = 1'b1;
      res.frame_kind      = fwd_i.kind;
      res.capture_seconds = fwd_i.seconds;
      res.elapsed_us      = first ? '0 : fwd_i.now - start_q;
      res.original_length = fwd_i.olen;
      res.included_length = fwd_i.ilen;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fwd_pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eapol_cnt_q  <= '0;
      beacon_cnt_q <= '0;
      probe_cnt_q  <= '0;
      start_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      eapol_cnt_q  <= eapol_cnt_d;
      beacon_cnt_q <= beacon_cnt_d;
      probe_cnt_q  <= probe_cnt_d;
      start_q      <= start_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (fwd_pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> design/wifi_frame_capture_filter.sv
// Path: an accepted item is written into the queue, then moved into the output
// register when that register is free or its result is being taken.
// Throughput: one item per cycle unless the queue is full or the output is stalled.
// Reset: counters and start time clear, config registers take their reset
// values (BSSID 0, limits 1023, snap length 65535), queue and output empty.
// Top level of the frame capture filter; depends on wfcf_pkg, wfcf_front,
// wfcf_fifo and wfcf_back.
`default_nettype none

module wifi_frame_capture_filter #(
  parameter int unsigned FifoDepth = wfcf_pkg::FifoDepth
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  wfcf_pkg::in_item_t          in_data_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output wfcf_pkg::out_item_t               out_data_o,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [wfcf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [wfcf_pkg::AddrW-1:0]        cfg_data_i
);

  wfcf_pkg::cfg_t cfg_q;
  wfcf_pkg::fwd_t fwd_in, fwd_out;
  logic full, fwd_valid, fwd_pop;

  assign cfg_ready_o = 1'b1;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_bssid     <= '0;
      cfg_q.eapol_limit      <= '1;
      cfg_q.beacon_limit     <= '1;
      cfg_q.probe_resp_limit <= '1;
      cfg_q.snap_length      <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wfcf_pkg::CfgTargetBssid:    cfg_q.target_bssid     <= cfg_data_i;
        wfcf_pkg::CfgEapolLimit:     cfg_q.eapol_limit      <= cfg_data_i[wfcf_pkg::CntW-1:0];
        wfcf_pkg::CfgBeaconLimit:    cfg_q.beacon_limit     <= cfg_data_i[wfcf_pkg::CntW-1:0];
        wfcf_pkg::CfgProbeRespLimit: cfg_q.probe_resp_limit <= cfg_data_i[wfcf_pkg::CntW-1:0];
        wfcf_pkg::CfgSnapLength:     cfg_q.snap_length      <= cfg_data_i[wfcf_pkg::SnapW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;

  wfcf_front u_front (
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .fwd_o  (fwd_in)
  );

  wfcf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .wr_data_i  (fwd_in),
    .full_o     (full),
    .pop_i      (fwd_pop),
    .rd_valid_o (fwd_valid),
    .rd_data_o  (fwd_out)
  );

  wfcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fwd_valid_i (fwd_valid),
    .fwd_i       (fwd_out),
    .fwd_pop_o   (fwd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> tb/wifi_frame_capture_filter_tb.sv
// Self-checking testbench for the frame capture filter: drives frame headers
// and register writes, predicts each result item in place and checks it.
// Depends on wfcf_pkg and wifi_frame_capture_filter.
`default_nettype none

module wifi_frame_capture_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wfcf_pkg::*;

  localparam int          ItemsPerPhase = 175;
  localparam int          RandPhases    = 6;
  localparam int          CalmPhase     = 3;
  localparam int          GapPercent    = 12;
  localparam int          DrainPause    = 4;
  localparam int          EndPause      = 10;
  localparam int          StuckLimit    = 2000;
  localparam logic [31:0] UsPerSec      = 32'd1_000_000;
  localparam logic [15:0] EthType       = {EthHi, EthLo};
  localparam logic [7:0]  FcProbeReq    = 8'h40;
  localparam logic [7:0]  FcData        = 8'h08;
  localparam logic [7:0]  FcOther       = 8'hff;
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd5;
  localparam logic [AddrW-1:0]   HomeBss   = 48'ha4c3_f05e_219b;
  localparam logic [AddrW-1:0]   AwayBss   = 48'h1122_3344_5566;
  localparam logic [CntW-1:0]    LimitMax  = 10'h3ff;
  localparam logic [SnapW-1:0]   SnapMax   = 16'hffff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [AddrW-1:0]    cfg_data_i  = '0;

  // Stimulus and expectations
  in_item_t  rx_frames[$];
  out_item_t expected_verdicts[$];
  logic      gaps_on = 1'b1;
  int        errors  = 0;
  int        stuck   = 0;
  logic [31:0] rx_clock = '0;

  // Shadow of the filter registers and capture state
  cfg_t filter_cfg = '{target_bssid: '0, eapol_limit: LimitMax, beacon_limit: LimitMax,
                       probe_resp_limit: LimitMax, snap_length: SnapMax};
  logic [CntW-1:0]  eapol_taken      = '0;
  logic [CntW-1:0]  beacon_taken     = '0;
  logic [CntW-1:0]  probe_resp_taken = '0;
  logic [TimeW-1:0] capture_start    = '0;

  wifi_frame_capture_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Classify one header, update counters and start time, give the verdict
  function automatic out_item_t classify_frame(input in_item_t f);
    out_item_t       r;
    logic [1:0]      kind;
    logic            typed;
    logic            first;
    logic            take;
    logic [LenW-1:0] olen;
    r = '0;
    kind = KindEapol;
    typed = 1'b1;
    take = 1'b0;
    if (f.mode) begin
      eapol_taken = '0;
      beacon_taken = '0;
      probe_resp_taken = '0;
      capture_start = '0;
      return r;
    end
    if (f.ethertype_window[31:16] == EthType || f.ethertype_window[23:8] == EthType ||
        f.ethertype_window[15:0] == EthType) begin
      kind = KindEapol;
    end else if (f.frame_control == FcBeacon) begin
      kind = KindBeacon;
    end else if (f.frame_control == FcProbeResp) begin
      kind = KindProbeResp;
    end else begin
      typed = 1'b0;
    end
    if (!typed) return r;
    if (f.addr_one != filter_cfg.target_bssid && f.addr_two != filter_cfg.target_bssid &&
        f.addr_three != filter_cfg.target_bssid) return r;
    first = (eapol_taken == 0 && beacon_taken == 0 && probe_resp_taken == 0);
    case (kind)
      KindEapol: begin
        if (eapol_taken < filter_cfg.eapol_limit) begin
          eapol_taken++;
          take = 1'b1;
        end
      end
      KindBeacon: begin
        if (beacon_taken < filter_cfg.beacon_limit) begin
          beacon_taken++;
          take = 1'b1;
        end
      end
      KindProbeResp: begin
        if (probe_resp_taken < filter_cfg.probe_resp_limit) begin
          probe_resp_taken++;
          take = 1'b1;
        end
      end
      default: ;
    endcase
    if (!take) return r;
    if (first) capture_start = f.now_us;
    // Strip the FCS from management frames, floor at zero
    olen = f.signal_length;
    if (f.is_management) olen = (olen >= FcsLen) ? olen - FcsLen : '0;
    r.captured = 1'b1;
    r.frame_kind = kind;
    r.capture_seconds = SecW'(f.now_us / UsPerSec);
    r.elapsed_us = f.now_us - capture_start;
    r.original_length = olen;
    r.included_length = ({4'b0, olen} > filter_cfg.snap_length) ?
                        filter_cfg.snap_length[LenW-1:0] : olen;
    return r;
  endfunction

  function automatic in_item_t frame_hdr(input logic [7:0] fc, input logic [AddrW-1:0] a1,
                                         input logic [AddrW-1:0] a2,
                                         input logic [AddrW-1:0] a3,
                                         input logic [31:0] win, input logic [LenW-1:0] slen,
                                         input logic mgmt, input logic [31:0] now);
    in_item_t f;
    f = '0;
    f.frame_control = fc;
    f.addr_one = a1;
    f.addr_two = a2;
    f.addr_three = a3;
    f.ethertype_window = win;
    f.signal_length = slen;
    f.is_management = mgmt;
    f.now_us = now;
    return f;
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[AddrW-1:0];
  endfunction

  function automatic logic [CntW-1:0] pick_limit();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = 0;
      1: v = $urandom_range(8, 1);
      2: v = LimitMax;
      default: v = $urandom;
    endcase
    return v[CntW-1:0];
  endfunction

  // Mostly frames of a capturable kind aimed at the target; the rest noise
  function automatic in_item_t random_frame();
    in_item_t    f;
    logic [31:0] v;
    int          pick;
    v = $urandom;
    f.mode = ($urandom_range(99) < 4);
    f.frame_control = v[7:0];
    f.addr_one = rand_addr();
    f.addr_two = rand_addr();
    f.addr_three = rand_addr();
    f.ethertype_window = $urandom;
    v = ($urandom_range(3) == 0) ? $urandom_range(8) : $urandom;
    f.signal_length = v[LenW-1:0];
    f.is_management = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 30) begin
      case ($urandom_range(2))
        0: f.ethertype_window[31:16] = EthType;
        1: f.ethertype_window[23:8] = EthType;
        default: f.ethertype_window[15:0] = EthType;
      endcase
    end else if (pick < 55) begin
      f.frame_control = FcBeacon;
    end else if (pick < 80) begin
      f.frame_control = FcProbeResp;
    end else if (pick < 90) begin
      f.frame_control = $urandom_range(1) ? FcProbeReq : FcData;
    end
    pick = $urandom_range(99);
    if (pick < 30) f.addr_one = filter_cfg.target_bssid;
    else if (pick < 55) f.addr_two = filter_cfg.target_bssid;
    else if (pick < 80) f.addr_three = filter_cfg.target_bssid;
    if (pick < 8) f.addr_three = filter_cfg.target_bssid;
    // Advance a running receive clock, with occasional jumps anywhere
    if ($urandom_range(3) == 0) begin
      f.now_us = $urandom;
    end else begin
      rx_clock = rx_clock + $urandom_range(4_000_000);
      f.now_us = rx_clock;
    end
    return f;
  endfunction

  // Append one header to the pending items
  task automatic queue_frame(input in_item_t f);
    rx_frames = {rx_frames, f};
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // Write one register and mirror it once the write is taken
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgTargetBssid:    filter_cfg.target_bssid = val;
      CfgEapolLimit:     filter_cfg.eapol_limit = val[CntW-1:0];
      CfgBeaconLimit:    filter_cfg.beacon_limit = val[CntW-1:0];
      CfgProbeRespLimit: filter_cfg.probe_resp_limit = val[CntW-1:0];
      CfgSnapLength:     filter_cfg.snap_length = val[SnapW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [AddrW-1:0] bssid, input logic [CntW-1:0] el,
                                input logic [CntW-1:0] bl, input logic [CntW-1:0] pl,
                                input logic [SnapW-1:0] snap);
    write_reg(CfgTargetBssid, bssid);
    write_reg(CfgEapolLimit, AddrW'(el));
    write_reg(CfgBeaconLimit, AddrW'(bl));
    write_reg(CfgProbeRespLimit, AddrW'(pl));
    write_reg(CfgSnapLength, AddrW'(snap));
  endtask

  // Wait until every header is sent and every verdict is back
  task automatic drain();
    do @(posedge clk_i);
    while (rx_frames.size() != 0 || in_valid_i || expected_verdicts.size() != 0);
    repeat (DrainPause) @(posedge clk_i);
  endtask

  // Driver: predict on acceptance, then hold, idle or advance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_verdicts = {expected_verdicts, classify_frame(in_data_i)};
      end
      if (!in_valid_i || !in_stall_o) begin
        if (rx_frames.size() != 0 && !(gaps_on && $urandom_range(99) < GapPercent)) begin
          in_data_i <= rx_frames.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result item against the oldest verdict
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          $error("result item with none expected: %p", out_data_o);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          compare_field("captured", 32'(want.captured), 32'(out_data_o.captured));
          compare_field("frame_kind", 32'(want.frame_kind), 32'(out_data_o.frame_kind));
          compare_field("capture_seconds", 32'(want.capture_seconds),
                        32'(out_data_o.capture_seconds));
          compare_field("elapsed_us", want.elapsed_us, out_data_o.elapsed_us);
          compare_field("original_length", 32'(want.original_length),
                        32'(out_data_o.original_length));
          compare_field("included_length", 32'(want.included_length),
                        32'(out_data_o.included_length));
        end
      end
      out_stall_i <= gaps_on && ($urandom_range(99) < GapPercent);
    end
  end

  // Watchdog: end the run if no channel moves an item for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck >= StuckLimit) begin
      $display("[wifi_frame_capture_filter] ERROR");
      $finish;
    end
  end

  initial begin
    logic [AddrW-1:0] bssid;
    logic [SnapW-1:0] snap;
    logic [31:0]      v;
    in_item_t         clr;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: target BSSID zero, limits and snap length at maximum
    queue_frame(frame_hdr(FcBeacon, '0, AwayBss, AwayBss, '0, 12'd100, 1'b1,
                          32'd5_000_000));
    queue_frame(frame_hdr(FcProbeResp, AwayBss, AwayBss, '0, '0, 12'd60, 1'b0,
                          32'd7_500_123));
    queue_frame(frame_hdr(FcData, AwayBss, '0, AwayBss, 32'h888e_0000, 12'd90,
                          1'b0, 32'd7_600_000));
    drain();

    // Tight limits, short snap length, unused register index
    apply_settings(HomeBss, 10'd2, 10'd0, LimitMax, 16'd100);
    write_reg(CfgUnused, '1);
    queue_frame('1);
    // EAPOL wins over a beacon frame-control byte
    queue_frame(frame_hdr(FcBeacon, '1, HomeBss, '1, 32'h888e_ffff, 12'hfff,
                          1'b0, 32'hffff_ffff));
    // Short management frame, elapsed time wraps
    queue_frame(frame_hdr('0, '0, '0, HomeBss, 32'h0088_8e00, 12'd3, 1'b1, '0));
    // EAPOL over its limit, beacon with limit zero
    queue_frame(frame_hdr('0, HomeBss, '0, '0, 32'h1234_888e, 12'd50, 1'b0,
                          32'd1_000_000));
    queue_frame(frame_hdr(FcBeacon, HomeBss, '0, '0, '0, 12'd50, 1'b1,
                          32'd2_000_000));
    queue_frame(frame_hdr(FcProbeResp, HomeBss, '0, '0, '0, 12'd4, 1'b1,
                          32'd12_345_678));
    queue_frame(frame_hdr(FcProbeResp, '0, HomeBss, '0, '0, 12'd104, 1'b1,
                          32'd999_999));
    queue_frame(frame_hdr(FcProbeResp, '0, '0, HomeBss, '0, 12'd105, 1'b1,
                          32'd4_294_000_000));
    // Kinds that are never captured and near misses on the ethertype
    queue_frame(frame_hdr(FcProbeReq, HomeBss, HomeBss, HomeBss, '0, 12'd80,
                          1'b1, 32'd3));
    queue_frame(frame_hdr(FcData, HomeBss, '0, '0, '0, 12'd80, 1'b0, 32'd4));
    queue_frame(frame_hdr(FcOther, HomeBss, '0, '0, '0, 12'd80, 1'b0, 32'd5));
    queue_frame(frame_hdr('0, HomeBss, '0, '0, 32'h8e88_0000, 12'd80, 1'b0, 32'd6));
    queue_frame(frame_hdr('0, HomeBss, '0, '0, 32'h8800_8e00, 12'd80, 1'b0, 32'd7));
    // No address matches the target
    queue_frame(frame_hdr(FcProbeResp, AwayBss, ~HomeBss, HomeBss ^ 48'h1, '0,
                          12'd80, 1'b0, 32'd8));
    // Clear, then the start time latches again
    clr = '0;
    clr.mode = 1'b1;
    queue_frame(clr);
    queue_frame(frame_hdr(FcProbeResp, '0, HomeBss, '0, '0, '0, 1'b0, 32'd42));
    queue_frame(frame_hdr('0, HomeBss, '0, '0, 32'h888e_888e, 12'hfff, 1'b1,
                          32'd1_000_042));
    drain();

    // Random phases, first two pinned to extreme settings
    for (int p = 0; p < RandPhases; p++) begin
      if (p == 0) begin
        apply_settings('1, LimitMax, LimitMax, LimitMax, '0);
      end else if (p == 1) begin
        apply_settings('0, 10'd0, 10'd3, 10'd1, SnapMax);
      end else begin
        case ($urandom_range(2))
          0: bssid = '0;
          1: bssid = '1;
          default: bssid = rand_addr();
        endcase
        v = $urandom;
        case ($urandom_range(3))
          0: snap = '0;
          1: snap = SnapW'($urandom_range(4095));
          2: snap = SnapMax;
          default: snap = v[SnapW-1:0];
        endcase
        apply_settings(bssid, pick_limit(), pick_limit(), pick_limit(), snap);
      end
      gaps_on <= (p != CalmPhase);
      repeat (ItemsPerPhase) queue_frame(random_frame());
      drain();
    end

    repeat (EndPause) @(posedge clk_i);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("[wifi_frame_capture_filter] OK");
    end else begin
      $display("[wifi_frame_capture_filter] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
